@@ sv/b2a_pkg.sv @@
package b2a_pkg;

    localparam int unsigned BIN_W    = 16;
    localparam int unsigned DIGITS   = 5;
    localparam int unsigned BCD_W    = 4 * DIGITS;
    localparam int unsigned NUM_SLOT = DIGITS + 1;

    localparam logic [1:0] KIND_U8   = 2'd0;
    localparam logic [1:0] KIND_U16  = 2'd1;
    localparam logic [1:0] KIND_S16  = 2'd2;
    localparam logic [1:0] KIND_NONE = 2'd3;

    localparam logic [7:0] ASCII_ZERO = 8'h30;
    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_MINUS   = 8'h2D;
    localparam logic [7:0] CH_SPACE   = 8'h20;

    // one request in flight along the conversion row
    typedef struct packed {
        logic [BIN_W-1:0] bin;
        logic [BCD_W-1:0] bcd;
        logic [BIN_W-1:0] raw;
        logic [7:0]       sign_char;
        logic             has_sign;
        logic             wide;
        logic             dec;
        logic             fill;
    } item_t;

endpackage

@@ sv/b2a_cell.sv @@
module b2a_cell (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           advance,
    input  logic           in_valid,
    input  b2a_pkg::item_t in_item,
    output logic           out_valid,
    output b2a_pkg::item_t out_item
);

    logic           valid_reg;
    logic           valid_next;
    b2a_pkg::item_t item_reg;
    b2a_pkg::item_t item_next;
    logic [b2a_pkg::BCD_W-1:0] adj;

    // one shift-and-add-three step
    always_comb
    begin
        for (int k = 0; k < b2a_pkg::DIGITS; k++)
        begin
            if (in_item.bcd[4*k +: 4] >= 4'd5)
            begin
                adj[4*k +: 4] = in_item.bcd[4*k +: 4] + 4'd3;
            end
            else
            begin
                adj[4*k +: 4] = in_item.bcd[4*k +: 4];
            end
        end
        item_next     = in_item;
        item_next.bcd = {adj[b2a_pkg::BCD_W-2:0], in_item.bin[b2a_pkg::BIN_W-1]};
        item_next.bin = {in_item.bin[b2a_pkg::BIN_W-2:0], 1'b0};
        valid_next    = advance ? in_valid : valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            item_reg <= item_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_item  = item_reg;

endmodule

@@ sv/b2a_ser.sv @@
module b2a_ser (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           item_valid,
    input  b2a_pkg::item_t item,
    output logic           can_load,
    output logic           out_valid,
    input  logic           out_ready,
    output logic [7:0]     char_byte,
    output logic           last
);

    localparam int unsigned NS = b2a_pkg::NUM_SLOT;

    logic [7:0]    slot_reg [NS];
    logic [7:0]    slot_next [NS];
    logic [NS-1:0] mask_reg;
    logic [NS-1:0] mask_next;
    logic [NS-1:0] new_mask;
    logic [NS-1:0] pick;
    logic [NS-1:0] rem;
    logic [2:0]    idx;
    logic          emit;
    logic          load;
    logic          seen;
    logic [3:0]    dig;
    logic [7:0]    char_reg;
    logic [7:0]    char_next;
    logic          last_reg;
    logic          last_next;
    logic          valid_reg;
    logic          valid_next;

    // lowest pending slot goes out first
    always_comb
    begin
        pick = '0;
        idx  = '0;
        for (int k = NS - 1; k >= 0; k--)
        begin
            if (mask_reg[k])
            begin
                pick = '0;
                pick[k] = 1'b1;
                idx = 3'(k);
            end
        end
        rem      = mask_reg & ~pick;
        emit     = (mask_reg != '0) && (!valid_reg || out_ready);
        can_load = (mask_reg == '0) || (emit && (rem == '0));
        load     = can_load && item_valid;
    end

    // slot 0 is the sign, slots 1 to 5 the digits from the top; in raw mode slots 4 and 5 hold the high and low byte
    always_comb
    begin
        seen = item.fill;
        new_mask = '0;
        slot_next[0] = item.sign_char;
        new_mask[0]  = item.has_sign;
        for (int k = 1; k < NS; k++)
        begin
            dig = item.bcd[4*(NS-1-k) +: 4];
            if (dig != 4'd0)
            begin
                seen = 1'b1;
            end
            if (item.dec)
            begin
                slot_next[k] = b2a_pkg::ASCII_ZERO | {4'd0, dig};
                new_mask[k]  = ((k >= 3) || item.wide) && (seen || (k == NS - 1));
            end
            else
            begin
                slot_next[k] = (k == NS - 1) ? item.raw[7:0] : item.raw[15:8];
                new_mask[k]  = (k == NS - 1) || ((k == NS - 2) && item.wide);
            end
        end
    end

    always_comb
    begin
        priority if (load)
        begin
            mask_next = new_mask;
        end
        else if (emit)
        begin
            mask_next = rem;
        end
        else
        begin
            mask_next = mask_reg;
        end

        char_next  = char_reg;
        last_next  = last_reg;
        valid_next = valid_reg;
        priority if (emit)
        begin
            char_next  = slot_reg[idx];
            last_next  = (rem == '0);
            valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg  <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            mask_reg  <= mask_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        char_reg <= char_next;
        last_reg <= last_next;
        if (load)
        begin
            for (int k = 0; k < NS; k++)
            begin
                slot_reg[k] <= slot_next[k];
            end
        end
    end

    assign out_valid = valid_reg;
    assign char_byte = char_reg;
    assign last      = last_reg;

endmodule

@@ sv/binary_to_ascii_decimal_formatter_unit.sv @@
// Binary to ASCII decimal formatter.
// Input channel (in_valid / in_ready): one request carries req_type, value,
// decimal_mode and zero_fill. Output channel (out_valid / out_ready): one
// byte per transfer in char_byte, with last set on the final byte of the
// request. A request of kind 3 is taken and gives no bytes.
// The magnitude runs through a row of 16 shift-and-add-three cells, one
// per bit, each holding the request in a register, ahead of the serializer.
// The serializer sends one byte per cycle while out_ready is high: a
// request gives 1 to 6 bytes, and the next request's bytes follow
// without a gap; the row is filled while bytes are still being sent.
// When out_ready is low the output byte holds, and the row and input stall
// together once the serializer has a request waiting.
// Reset clears every valid flag; no byte is pending after reset.
module binary_to_ascii_decimal_formatter_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  req_type,
    input  logic [15:0] value,
    input  logic        decimal_mode,
    input  logic        zero_fill,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  char_byte,
    output logic        last
);

    localparam int unsigned NC = b2a_pkg::BIN_W;

    b2a_pkg::item_t chain_item [NC+1];
    logic           chain_valid [NC+1];
    logic           advance;
    logic           can_load;
    logic           negative;

    always_comb
    begin
        negative = (req_type == b2a_pkg::KIND_S16) && value[15];
        chain_item[0] = '0;
        unique case (req_type)
            b2a_pkg::KIND_U8:
            begin
                chain_item[0].raw = {8'd0, value[7:0]};
            end
            default:
            begin
                // most negative value wraps to 0x8000, its magnitude
                chain_item[0].raw = negative ? (16'd0 - value) : value;
            end
        endcase
        chain_item[0].bin      = chain_item[0].raw;
        chain_item[0].has_sign = (req_type == b2a_pkg::KIND_S16);
        chain_item[0].wide     = (req_type != b2a_pkg::KIND_U8);
        chain_item[0].dec      = decimal_mode;
        chain_item[0].fill     = zero_fill;
        priority if (value == 16'd0)
        begin
            chain_item[0].sign_char = b2a_pkg::CH_SPACE;
        end
        else if (value[15])
        begin
            chain_item[0].sign_char = b2a_pkg::CH_MINUS;
        end
        else
        begin
            chain_item[0].sign_char = b2a_pkg::CH_PLUS;
        end
        advance        = !chain_valid[NC] || can_load;
        chain_valid[0] = in_valid && (req_type != b2a_pkg::KIND_NONE);
    end

    assign in_ready = advance;

    for (genvar g = 0; g < NC; g++)
    begin : g_cell
        b2a_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .advance   (advance),
            .in_valid  (chain_valid[g]),
            .in_item   (chain_item[g]),
            .out_valid (chain_valid[g+1]),
            .out_item  (chain_item[g+1])
        );
    end

    b2a_ser u_ser (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (chain_valid[NC]),
        .item       (chain_item[NC]),
        .can_load   (can_load),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .char_byte  (char_byte),
        .last       (last)
    );

endmodule
